/* src/ume_pkg.sv */
// ---------------------------------------------------------------------------
// ume_pkg
// Shared constants, payload types and helpers for the unique mesh edge
// extractor: edge keys, cell and chain control structs, opcodes.
// ---------------------------------------------------------------------------
package ume_pkg;

    localparam int MAX_EDGES    = 256;
    localparam int INDEX_BITS   = 20;
    localparam int FIELD_BITS   = 20;
    localparam int KEY_BITS     = (INDEX_BITS < FIELD_BITS) ? INDEX_BITS : FIELD_BITS;
    localparam int CNT_BITS     = $clog2(MAX_EDGES + 1);
    localparam int PTR_BITS     = $clog2(MAX_EDGES);
    localparam int GROUP_BITS   = (PTR_BITS + 1) / 2;
    localparam int GROUP_SIZE   = 1 << GROUP_BITS;
    localparam int NUM_GROUPS   = (MAX_EDGES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GRP_IDX_BITS = $clog2(NUM_GROUPS);

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef logic [FIELD_BITS-1:0] ume_field_t;
    typedef logic [KEY_BITS-1:0]   ume_vtx_t;
    typedef logic [CNT_BITS-1:0]   ume_cnt_t;
    typedef logic [PTR_BITS-1:0]   ume_ptr_t;

    typedef struct packed {
        logic [1:0]  opcode;
        ume_field_t  vertex_index;
        logic        face_last;
    } ume_in_t;

    typedef struct packed {
        ume_field_t  edge_low;
        ume_field_t  edge_high;
        logic        edge_valid;
        logic        edge_last;
        logic        set_overflow;
    } ume_out_t;

    // lo in the upper half so that a plain unsigned compare orders by (lo, hi)
    typedef struct packed {
        ume_vtx_t lo;
        ume_vtx_t hi;
    } ume_key_t;

    typedef struct packed {
        logic     cmp_en;
        logic     shift_en;
        ume_key_t key;
    } ume_cell_ctrl_t;

    typedef struct packed {
        logic     cmp_en;
        logic     red_en;
        logic     commit_en;
        logic     full;
        logic     rd_grp_en;
        logic     rd_sel_en;
        ume_key_t key;
        ume_ptr_t rd_ptr;
        ume_cnt_t count;
    } ume_chain_ctrl_t;

    typedef struct packed {
        logic     dup;
        ume_key_t rd_key;
    } ume_chain_stat_t;

    function automatic ume_key_t ume_norm(input ume_vtx_t a, input ume_vtx_t b);
        ume_key_t k;
        begin
            if (a < b)
            begin
                k.lo = a;
                k.hi = b;
            end
            else
            begin
                k.lo = b;
                k.hi = a;
            end
            return k;
        end
    endfunction

endpackage

/* src/ume_edge_cell.sv */
// ---------------------------------------------------------------------------
// ume_edge_cell
// One slot of the sorted edge chain: holds an edge key, compares it with the
// broadcast key and on an insert takes its left neighbor's key or the new key.
// ---------------------------------------------------------------------------
module ume_edge_cell (
    input  logic                    clk,
    input  ume_pkg::ume_cell_ctrl_t ctrl,
    input  logic                    in_use,
    input  logic                    prev_ge,
    input  ume_pkg::ume_key_t       prev_key,
    output ume_pkg::ume_key_t       key,
    output logic                    ge,
    output logic                    eq
);
    import ume_pkg::*;

    ume_key_t key_reg;
    logic     ge_reg;
    logic     eq_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.cmp_en)
        begin
            // an unused slot counts as above every key
            ge_reg <= !in_use || !(key_reg < ctrl.key);
            eq_reg <= in_use && (key_reg == ctrl.key);
        end
        if (ctrl.shift_en && ge_reg)
        begin
            key_reg <= prev_ge ? prev_key : ctrl.key;
        end
    end

    assign key = key_reg;
    assign ge  = ge_reg;
    assign eq  = eq_reg;

endmodule

/* src/ume_edge_chain.sv */
// ---------------------------------------------------------------------------
// ume_edge_chain
// Row of edge cells kept sorted, with a registered duplicate reduction and a
// two-level registered read select.
// ---------------------------------------------------------------------------
module ume_edge_chain (
    input  logic                     clk,
    input  ume_pkg::ume_chain_ctrl_t ctrl,
    output ume_pkg::ume_chain_stat_t stat
);
    import ume_pkg::*;

    ume_key_t                key_arr [MAX_EDGES];
    logic [MAX_EDGES-1:0]    ge_arr;
    logic [MAX_EDGES-1:0]    eq_arr;
    logic [MAX_EDGES-1:0]    in_use;
    ume_cell_ctrl_t          cell_ctrl;

    ume_key_t                key_pad  [NUM_GROUPS][GROUP_SIZE];
    logic [GROUP_SIZE-1:0]   eq_pad   [NUM_GROUPS];
    logic [NUM_GROUPS-1:0]   grp_dup_reg;
    ume_key_t                grp_key_reg [NUM_GROUPS];
    ume_key_t                rd_key_reg;
    logic [GRP_IDX_BITS-1:0] grp_sel;
    logic                    dup;

    assign dup = |grp_dup_reg;

    assign cell_ctrl.cmp_en   = ctrl.cmp_en;
    assign cell_ctrl.shift_en = ctrl.commit_en && !dup && !ctrl.full;
    assign cell_ctrl.key      = ctrl.key;

    for (genvar i = 0; i < MAX_EDGES; i++)
    begin : g_cell
        assign in_use[i] = CNT_BITS'(i) < ctrl.count;
        if (i == 0)
        begin : g_head
            ume_edge_cell u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl),
                .in_use   (in_use[i]),
                .prev_ge  (1'b0),
                .prev_key ('0),
                .key      (key_arr[i]),
                .ge       (ge_arr[i]),
                .eq       (eq_arr[i])
            );
        end
        else
        begin : g_body
            ume_edge_cell u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl),
                .in_use   (in_use[i]),
                .prev_ge  (ge_arr[i-1]),
                .prev_key (key_arr[i-1]),
                .key      (key_arr[i]),
                .ge       (ge_arr[i]),
                .eq       (eq_arr[i])
            );
        end
    end

    // fold the row into groups, padding the tail group
    for (genvar g = 0; g < NUM_GROUPS; g++)
    begin : g_grp
        for (genvar j = 0; j < GROUP_SIZE; j++)
        begin : g_slot
            if (g * GROUP_SIZE + j < MAX_EDGES)
            begin : g_real
                assign key_pad[g][j] = key_arr[g * GROUP_SIZE + j];
                assign eq_pad[g][j]  = eq_arr[g * GROUP_SIZE + j];
            end
            else
            begin : g_fill
                assign key_pad[g][j] = '0;
                assign eq_pad[g][j]  = 1'b0;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.red_en)
            begin
                grp_dup_reg[g] <= |eq_pad[g];
            end
            if (ctrl.rd_grp_en)
            begin
                grp_key_reg[g] <= key_pad[g][ctrl.rd_ptr[GROUP_BITS-1:0]];
            end
        end
    end

    assign grp_sel = ctrl.rd_ptr[GROUP_BITS +: GRP_IDX_BITS];

    always_ff @(posedge clk)
    begin
        // a pointer at the end of a full set wraps to group 0, the read is a miss then
        if (ctrl.rd_sel_en)
        begin
            rd_key_reg <= grp_key_reg[grp_sel];
        end
    end

    assign stat.dup    = dup;
    assign stat.rd_key = rd_key_reg;

endmodule

/* src/unique_mesh_edge_extractor.sv */
// ---------------------------------------------------------------------------
// unique_mesh_edge_extractor
// Collects the unique undirected edges of a polygon mesh into a sorted set
// and reads them back in ascending order.
// ---------------------------------------------------------------------------
// Items are taken one at a time. A vertex that forms no edge (the first of a
// face), a clear and an unused opcode are handled in the idle state. Each edge
// inserted then passes through the cell chain (broadcast compare in every cell,
// registered duplicate reduction over cell groups, then a shift of the chain
// for a new edge if not full); a face's last vertex also sends its closing edge.
// A read passes through the two-level registered select and then waits, if
// need be, for the output register to free up; an input transfer can be taken
// while a read result still waits downstream. No clearing pass is needed
// after reset or clear.
module unique_mesh_edge_extractor (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ume_pkg::ume_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ume_pkg::ume_out_t out_data
);
    import ume_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_RED,
        S_COMMIT,
        S_RD_GRP,
        S_RD_SEL,
        S_RD_OUT
    } state_t;

    state_t          state_reg,      state_next;
    ume_cnt_t        edge_count_reg, edge_count_next;
    ume_cnt_t        read_ptr_reg,   read_ptr_next;
    logic            overflow_reg,   overflow_next;
    logic            seen_reg,       seen_next;
    ume_vtx_t        first_reg,      first_next;
    ume_vtx_t        prev_reg,       prev_next;
    ume_key_t        key_reg,        key_next;
    ume_key_t        key2_reg,       key2_next;
    logic            second_reg,     second_next;
    logic            hit_reg,        hit_next;
    logic            last_reg,       last_next;
    logic            out_valid_reg,  out_valid_next;
    ume_out_t        out_data_reg,   out_data_next;

    ume_chain_ctrl_t chain_ctrl;
    ume_chain_stat_t chain_stat;
    ume_vtx_t        vtx;
    logic            full;
    logic            in_xfer;

    assign vtx     = in_data.vertex_index[KEY_BITS-1:0];
    assign full    = edge_count_reg == CNT_BITS'(MAX_EDGES);
    assign in_ready = state_reg == S_IDLE;
    assign in_xfer  = in_valid && in_ready;

    assign chain_ctrl.cmp_en    = state_reg == S_CMP;
    assign chain_ctrl.red_en    = state_reg == S_RED;
    assign chain_ctrl.commit_en = state_reg == S_COMMIT;
    assign chain_ctrl.full      = full;
    assign chain_ctrl.rd_grp_en = state_reg == S_RD_GRP;
    assign chain_ctrl.rd_sel_en = state_reg == S_RD_SEL;
    assign chain_ctrl.key       = key_reg;
    assign chain_ctrl.rd_ptr    = read_ptr_reg[PTR_BITS-1:0];
    assign chain_ctrl.count     = edge_count_reg;

    ume_edge_chain u_chain (
        .clk  (clk),
        .ctrl (chain_ctrl),
        .stat (chain_stat)
    );

    always_comb
    begin
        state_next      = state_reg;
        edge_count_next = edge_count_reg;
        read_ptr_next   = read_ptr_reg;
        overflow_next   = overflow_reg;
        seen_next       = seen_reg;
        first_next      = first_reg;
        prev_next       = prev_reg;
        key_next        = key_reg;
        key2_next       = key2_reg;
        second_next     = second_reg;
        hit_next        = hit_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (in_data.opcode)
                        OP_ADD:
                        begin
                            if (!seen_reg)
                            begin
                                first_next = vtx;
                                prev_next  = vtx;
                                seen_next  = !in_data.face_last;
                            end
                            else
                            begin
                                key_next    = ume_norm(prev_reg, vtx);
                                key2_next   = ume_norm(vtx, first_reg);
                                second_next = in_data.face_last;
                                prev_next   = vtx;
                                if (in_data.face_last)
                                begin
                                    seen_next = 1'b0;
                                end
                                state_next = S_CMP;
                            end
                        end
                        OP_READ:
                        begin
                            hit_next   = read_ptr_reg < edge_count_reg;
                            last_next  = CNT_BITS'(read_ptr_reg + 1'b1) == edge_count_reg;
                            state_next = S_RD_GRP;
                        end
                        OP_CLEAR:
                        begin
                            edge_count_next = '0;
                            read_ptr_next   = '0;
                            overflow_next   = 1'b0;
                            seen_next       = 1'b0;
                            first_next      = '0;
                            prev_next       = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CMP:
            begin
                state_next = S_RED;
            end
            S_RED:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (!chain_stat.dup)
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        edge_count_next = edge_count_reg + 1'b1;
                    end
                end
                // closing edge of the face goes through the chain next
                if (second_reg)
                begin
                    key_next    = key2_reg;
                    second_next = 1'b0;
                    state_next  = S_CMP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD_GRP:
            begin
                state_next = S_RD_SEL;
            end
            S_RD_SEL:
            begin
                state_next = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (hit_reg)
                    begin
                        out_data_next.edge_low  = ume_field_t'(chain_stat.rd_key.lo);
                        out_data_next.edge_high = ume_field_t'(chain_stat.rd_key.hi);
                        out_data_next.edge_last = last_reg;
                        read_ptr_next           = read_ptr_reg + 1'b1;
                    end
                    else
                    begin
                        out_data_next.edge_low  = '0;
                        out_data_next.edge_high = '0;
                        out_data_next.edge_last = 1'b0;
                    end
                    out_data_next.edge_valid   = hit_reg;
                    out_data_next.set_overflow = overflow_reg;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            edge_count_reg <= '0;
            read_ptr_reg   <= '0;
            overflow_reg   <= 1'b0;
            seen_reg       <= 1'b0;
            first_reg      <= '0;
            prev_reg       <= '0;
            second_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_count_reg <= edge_count_next;
            read_ptr_reg   <= read_ptr_next;
            overflow_reg   <= overflow_next;
            seen_reg       <= seen_next;
            first_reg      <= first_next;
            prev_reg       <= prev_next;
            second_reg     <= second_next;
            hit_reg        <= hit_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        key2_reg     <= key2_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // set never grows past its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edge_count_reg <= CNT_BITS'(MAX_EDGES))
        else $error("edge count beyond capacity");

    // read pointer never passes the edge count
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        read_ptr_reg <= edge_count_reg)
        else $error("read pointer past edge count");

    // the set grows by one edge, and only on a chain commit
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        edge_count_reg > $past(edge_count_reg)
        |-> edge_count_reg == CNT_BITS'($past(edge_count_reg) + 1'b1)
            && $past(state_reg) == S_COMMIT)
        else $error("edge count grew outside a commit");

    // overflow is raised only by a commit against a full set
    a_overflow_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(overflow_reg) |-> $past(state_reg) == S_COMMIT && $past(full))
        else $error("overflow set without a full-set commit");

    // an exhausted read returns an all-zero edge
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.edge_valid
        |-> out_data_reg.edge_low == '0 && out_data_reg.edge_high == '0
            && !out_data_reg.edge_last)
        else $error("exhausted read carries edge data");

endmodule
